[hdl/dad_pkg.sv]
// Shared constants and register codes of the detection anchor decoder.
package dad_pkg;

	localparam int MAX_CLASSES    = 256;
	localparam int MAX_IMAGE_SIDE = 4096;

	localparam int CLS_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int PIX_W   = $clog2(MAX_IMAGE_SIDE);
	localparam int COORD_W = 16;
	localparam int SCORE_W = 16;
	localparam int ID_W    = 8;
	localparam int BOX_W   = 12;

	localparam int SCALE_W = 20;
	localparam int PAD_W   = 10;
	localparam int SIDE_W  = 13;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 3;

	localparam int FRAC_W = 23;
	localparam int CRN_W  = 19;
	localparam int PRD_W  = CRN_W + SCALE_W;
	localparam int CLP_W  = PIX_W + FRAC_W;
	localparam int DIF_W  = CLP_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd5;

	localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd16384;
	localparam logic [SCALE_W-1:0] RST_INVERSE_SCALE   = 20'd65536;
	localparam logic [SIDE_W-1:0]  RST_IMAGE_SIDE      = 13'd640;

endpackage

[hdl/dad_item_if.sv]
// Input channel carrying one class score item of an anchor.
interface dad_item_if;
	import dad_pkg::*;

	logic               valid;
	logic               ready;
	logic               first;
	logic               last;
	logic [COORD_W-1:0] center_x;
	logic [COORD_W-1:0] center_y;
	logic [COORD_W-1:0] box_width_in;
	logic [COORD_W-1:0] box_height_in;
	logic [SCORE_W-1:0] class_score;

	modport source (output valid, first, last, center_x, center_y, box_width_in,
		box_height_in, class_score, input ready);
	modport sink (input valid, first, last, center_x, center_y, box_width_in,
		box_height_in, class_score, output ready);
endinterface

[hdl/dad_result_if.sv]
// Output channel carrying one decoded detection.
interface dad_result_if;
	import dad_pkg::*;

	logic               valid;
	logic               ready;
	logic [ID_W-1:0]    class_idx;
	logic [SCORE_W-1:0] best_confidence;
	logic [BOX_W-1:0]   box_x;
	logic [BOX_W-1:0]   box_y;
	logic [BOX_W-1:0]   box_w;
	logic [BOX_W-1:0]   box_h;

	modport source (output valid, class_idx, best_confidence, box_x, box_y, box_w, box_h,
		input ready);
	modport sink (input valid, class_idx, best_confidence, box_x, box_y, box_w, box_h,
		output ready);
endinterface

[hdl/detection_anchor_decode.sv]
// Top level of the detection anchor decoder: running maximum and box mapping pipeline.
//
//   channel   direction  handshake      carries
//   items     in         valid/ready    first, last, box centre and size, class score
//   results   out        valid/ready    class id, confidence, box corner and size
//   cfg       in         cfg_we         register index and write data
//
// One item is taken per cycle unless stalled; the running maximum updates on the transfer itself.
// A closing item passes four register stages (corners, products, clamp, output), and its
// detection is presented from the output stage once its last item has passed through them.
// Reset clears the anchor state, the stage valid flags and loads the register defaults.
// A stalled result holds only the stages behind it that are full; empty stages still fill.
module detection_anchor_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	dad_item_if.sink                          items,
	dad_result_if.source                      results,
	input  logic                              cfg_we,
	input  logic [dad_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dad_pkg::CFG_W-1:0]         cfg_data
);
	import dad_pkg::*;

	logic [SCORE_W-1:0] score_threshold_q;
	logic [SCALE_W-1:0] inverse_scale_q;
	logic [PAD_W-1:0]   pad_left_q;
	logic [PAD_W-1:0]   pad_top_q;
	logic [SIDE_W-1:0]  image_width_q;
	logic [SIDE_W-1:0]  image_height_q;

	logic [SCORE_W-1:0] top_score_q, top_score_d;
	logic [CLS_W-1:0]   best_class_q, best_class_d;
	logic [CLS_W-1:0]   class_count_q, class_count_d;
	logic [COORD_W-1:0] held_cx_q, held_cx_d;
	logic [COORD_W-1:0] held_cy_q, held_cy_d;
	logic [COORD_W-1:0] held_w_q, held_w_d;
	logic [COORD_W-1:0] held_h_q, held_h_d;

	logic accept, adv1, adv2, adv3, adv4, emit;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [SCORE_W-1:0]      score_s1, score_s2, score_s3, score_s4;
	logic [CLS_W-1:0]        cls_s1, cls_s2, cls_s3, cls_s4;
	logic signed [CRN_W-1:0] x0_s1, x1_s1, y0_s1, y1_s1;
	logic signed [PRD_W-1:0] x0_s2, x1_s2, y0_s2, y1_s2;
	logic [CLP_W-1:0]        x0_s3, x1_s3, y0_s3, y1_s3;
	logic [BOX_W-1:0]        bx_s4, by_s4, bw_s4, bh_s4;

	logic signed [CRN_W-1:0] cx2, cy2, wd, ht, padx, pady;
	logic [PIX_W-1:0]        side_max_x, side_max_y;
	logic signed [DIF_W-1:0] dx, dy;
	logic                    keep_x, keep_y;
	logic [31:0]             cls_wide;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_threshold_q <= RST_SCORE_THRESHOLD;
			inverse_scale_q   <= RST_INVERSE_SCALE;
			pad_left_q        <= '0;
			pad_top_q         <= '0;
			image_width_q     <= RST_IMAGE_SIDE;
			image_height_q    <= RST_IMAGE_SIDE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCORE_THRESHOLD: score_threshold_q <= cfg_data[SCORE_W-1:0];
				REG_INVERSE_SCALE:   inverse_scale_q   <= cfg_data[SCALE_W-1:0];
				REG_PAD_LEFT:        pad_left_q        <= cfg_data[PAD_W-1:0];
				REG_PAD_TOP:         pad_top_q         <= cfg_data[PAD_W-1:0];
				REG_IMAGE_WIDTH:     image_width_q     <= cfg_data[SIDE_W-1:0];
				REG_IMAGE_HEIGHT:    image_height_q    <= cfg_data[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv4   = !v_s4 || results.ready;
	assign adv3   = !v_s3 || adv4;
	assign adv2   = !v_s2 || adv3;
	assign adv1   = !v_s1 || adv2;
	assign items.ready = adv1;
	assign accept = items.valid && adv1;

	// Running maximum; the earliest class wins a tie.
	always_comb begin
		top_score_d   = top_score_q;
		best_class_d  = best_class_q;
		class_count_d = class_count_q;
		held_cx_d     = held_cx_q;
		held_cy_d     = held_cy_q;
		held_w_d      = held_w_q;
		held_h_d      = held_h_q;
		if (items.first) begin
			top_score_d   = items.class_score;
			best_class_d  = '0;
			class_count_d = '0;
			held_cx_d     = items.center_x;
			held_cy_d     = items.center_y;
			held_w_d      = items.box_width_in;
			held_h_d      = items.box_height_in;
		end else if ((CLS_W+1)'(class_count_q) + (CLS_W+1)'(1)
				< (CLS_W+1)'(MAX_CLASSES)) begin
			class_count_d = class_count_q + CLS_W'(1);
			if (items.class_score > top_score_q) begin
				top_score_d  = items.class_score;
				best_class_d = class_count_q + CLS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_score_q   <= '0;
			best_class_q  <= '0;
			class_count_q <= '0;
			held_cx_q     <= '0;
			held_cy_q     <= '0;
			held_w_q      <= '0;
			held_h_q      <= '0;
		end else if (accept) begin
			top_score_q   <= top_score_d;
			best_class_q  <= best_class_d;
			class_count_q <= class_count_d;
			held_cx_q     <= held_cx_d;
			held_cy_q     <= held_cy_d;
			held_w_q      <= held_w_d;
			held_h_q      <= held_h_d;
		end
	end

	// Corners in units of 1/128 pixel, with the padding removed.
	assign cx2  = $signed(CRN_W'({held_cx_d, 1'b0}));
	assign cy2  = $signed(CRN_W'({held_cy_d, 1'b0}));
	assign wd   = $signed(CRN_W'(held_w_d));
	assign ht   = $signed(CRN_W'(held_h_d));
	assign padx = $signed(CRN_W'({pad_left_q, 7'b0}));
	assign pady = $signed(CRN_W'({pad_top_q, 7'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= accept && items.last && !(top_score_d < score_threshold_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			score_s1 <= top_score_d;
			cls_s1   <= best_class_d;
			x0_s1    <= cx2 - wd - padx;
			x1_s1    <= cx2 + wd - padx;
			y0_s1    <= cy2 - ht - pady;
			y1_s1    <= cy2 + ht - pady;
		end
	end

	// Scaling by the reciprocal, one multiplier per corner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			score_s2 <= score_s1;
			cls_s2   <= cls_s1;
			x0_s2    <= x0_s1 * $signed({1'b0, inverse_scale_q});
			x1_s2    <= x1_s1 * $signed({1'b0, inverse_scale_q});
			y0_s2    <= y0_s1 * $signed({1'b0, inverse_scale_q});
			y1_s2    <= y1_s1 * $signed({1'b0, inverse_scale_q});
		end
	end

	function automatic logic [PIX_W-1:0] side_max(input logic [SIDE_W-1:0] s);
		logic [PIX_W-1:0] r;
		if (s == '0) begin
			r = '0;
		end else if (32'(s) > MAX_IMAGE_SIDE) begin
			r = PIX_W'(MAX_IMAGE_SIDE - 1);
		end else begin
			r = PIX_W'(s - SIDE_W'(1));
		end
		return r;
	endfunction

	function automatic logic [CLP_W-1:0] clamp(input logic signed [PRD_W-1:0] v,
			input logic [PIX_W-1:0] smax);
		logic [CLP_W-1:0] hi;
		logic [CLP_W-1:0] r;
		hi = {smax, FRAC_W'(0)};
		if (v[PRD_W-1]) begin
			r = '0;
		end else if (v[PRD_W-2:0] > (PRD_W-1)'(hi)) begin
			r = hi;
		end else begin
			r = v[CLP_W-1:0];
		end
		return r;
	endfunction

	assign side_max_x = side_max(image_width_q);
	assign side_max_y = side_max(image_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			score_s3 <= score_s2;
			cls_s3   <= cls_s2;
			x0_s3    <= clamp(x0_s2, side_max_x);
			x1_s3    <= clamp(x1_s2, side_max_x);
			y0_s3    <= clamp(y0_s2, side_max_y);
			y1_s3    <= clamp(y1_s2, side_max_y);
		end
	end

	// A box survives only if both sides span at least one whole pixel.
	assign dx     = $signed({1'b0, x1_s3}) - $signed({1'b0, x0_s3});
	assign dy     = $signed({1'b0, y1_s3}) - $signed({1'b0, y0_s3});
	assign keep_x = !dx[DIF_W-1] && (dx[DIF_W-2:FRAC_W] != '0);
	assign keep_y = !dy[DIF_W-1] && (dy[DIF_W-2:FRAC_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= v_s3 && keep_x && keep_y;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			score_s4 <= score_s3;
			cls_s4   <= cls_s3;
			bx_s4    <= x0_s3[FRAC_W +: BOX_W];
			by_s4    <= y0_s3[FRAC_W +: BOX_W];
			bw_s4    <= dx[FRAC_W +: BOX_W];
			bh_s4    <= dy[FRAC_W +: BOX_W];
		end
	end

	assign cls_wide                = 32'(cls_s4);
	assign results.valid           = v_s4;
	assign results.class_idx       = cls_wide[ID_W-1:0];
	assign results.best_confidence = score_s4;
	assign results.box_x           = bx_s4;
	assign results.box_y           = by_s4;
	assign results.box_w           = bw_s4;
	assign results.box_h           = bh_s4;
	assign emit                    = results.valid && results.ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !items.last |=> !v_s1)
		else $error("non-closing item entered the corner stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.box_w != '0) && (results.box_h != '0))
		else $error("empty box presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.best_confidence < score_threshold_q))
		else $error("detection below threshold presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !emit |=> v_s4)
		else $error("stalled detection lost");

endmodule
